FILE: design/wpt_pkg.sv
// Shared types and constants for the pair traffic counter.
package wpt_pkg;

    localparam int TABLE_ENTRIES  = 32;
    localparam int MAX_BSSIDS     = 4;
    localparam int NUM_BSSID_REGS = 4;
    localparam int MAC_W          = 48;
    localparam int CNT_W          = 32;
    localparam int LEN_W          = 16;
    localparam int FLAGS_W        = 8;
    localparam int BCNT_W         = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 48;
    localparam int SLOT_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_NUM = 3'd4;

    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_DUMP  = 1'b1;

    localparam logic [1:0]       DS_MASK   = 2'b11;
    localparam int               RETRY_BIT = 3;
    localparam logic [MAC_W-1:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    typedef logic [MAC_W-1:0] mac_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef mac_t bssid_set_t [NUM_BSSID_REGS];

    typedef enum logic [1:0] {
        OP_NONE,
        OP_RX,
        OP_TX,
        OP_RETRY
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DUMP,
        ST_EMPTY
    } state_t;

    // Classified frame handed to every cell of the table.
    typedef struct packed {
        logic             valid;
        op_t              op;
        mac_t             bssid;
        mac_t             station;
        logic [LEN_W-1:0] len;
    } req_t;

    typedef struct packed {
        mac_t bssid;
        mac_t station;
        cnt_t rx_octets;
        cnt_t rx_frames;
        cnt_t tx_octets;
        cnt_t tx_frames;
        cnt_t tx_retry_cnt;
    } entry_t;

endpackage

FILE: design/wifi_pair_traffic_counter_unit.sv
// Top level: config registers, cell chain, dump sequencer and output register.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_stall | func flags dst_mac src_mac frame_length
//  out     | out_valid/out_stall | pair_bssid pair_station rx_* tx_* drop_total
//          |                     | entry_valid last
//  cfg     | cfg_write           | cfg_index cfg_data
//
// A frame item is registered and classified into a request register; then every
// cell matches the key in parallel and the hit or lowest free cell updates.
// A dump loads the used mask, then steps while the output is free: the whole cell
// chain rotates by one per step, cell 0 feeding the output register. A dump of
// an empty table emits a single item with entry_valid low and last set.
// Reset clears the cell used bits at once; no clearing pass is needed.
// Input is stalled while a frame is classified and for the whole dump.
module wifi_pair_traffic_counter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [wpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wpt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [wpt_pkg::FLAGS_W-1:0]     flags,
    input  logic [wpt_pkg::MAC_W-1:0]       dst_mac,
    input  logic [wpt_pkg::MAC_W-1:0]       src_mac,
    input  logic [wpt_pkg::LEN_W-1:0]       frame_length,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [wpt_pkg::MAC_W-1:0]       pair_bssid,
    output logic [wpt_pkg::MAC_W-1:0]       pair_station,
    output logic [wpt_pkg::CNT_W-1:0]       rx_byte_total,
    output logic [wpt_pkg::CNT_W-1:0]       rx_frame_total,
    output logic [wpt_pkg::CNT_W-1:0]       tx_byte_total,
    output logic [wpt_pkg::CNT_W-1:0]       tx_frame_total,
    output logic [wpt_pkg::CNT_W-1:0]       tx_retry_total,
    output logic [wpt_pkg::CNT_W-1:0]       drop_total,
    output logic                            entry_valid,
    output logic                            last
);

    localparam int N = wpt_pkg::TABLE_ENTRIES;

    wpt_pkg::bssid_set_t             bssid_reg;
    logic [wpt_pkg::BCNT_W-1:0]      watch_num_reg;

    wpt_pkg::state_t                 state_reg;
    wpt_pkg::state_t                 state_next;
    logic [N-1:0]                    dmask_reg;
    logic [N-1:0]                    dmask_next;
    logic [wpt_pkg::SLOT_W-1:0]      dcnt_reg;
    logic [wpt_pkg::SLOT_W-1:0]      dcnt_next;
    wpt_pkg::cnt_t                   drop_reg;
    wpt_pkg::cnt_t                   drop_next;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    wpt_pkg::entry_t                 res_reg;
    wpt_pkg::entry_t                 res_next;
    logic                            res_entry_reg;
    logic                            res_entry_next;
    logic                            res_last_reg;
    logic                            res_last_next;
    wpt_pkg::cnt_t                   res_drop_reg;
    logic                            emit;

    logic                            in_accept;
    logic                            frame_accept;
    logic                            cls_busy;
    wpt_pkg::req_t                   req;
    logic                            out_free;
    logic                            shift;
    logic                            any_hit;
    logic [N-1:0]                    hit_vec;
    logic [N-1:0]                    alloc_vec;
    logic [N-1:0]                    used_vec;
    logic [N:0]                      free_chain;
    wpt_pkg::entry_t                 cell_entry [N];

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wpt_pkg::NUM_BSSID_REGS; i++)
                bssid_reg[i] <= '0;
            watch_num_reg <= '0;
        end
        else if (cfg_write)
        begin
            for (int i = 0; i < wpt_pkg::NUM_BSSID_REGS; i++)
                if (cfg_index == wpt_pkg::CFG_IDX_W'(i))
                    bssid_reg[i] <= cfg_data[wpt_pkg::MAC_W-1:0];
            if (cfg_index == wpt_pkg::CFG_WATCH_NUM)
                watch_num_reg <= cfg_data[wpt_pkg::BCNT_W-1:0];
        end
    end

    assign in_stall     = cls_busy || (state_reg != wpt_pkg::ST_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign frame_accept = in_accept && func == wpt_pkg::FUNC_FRAME;

    wpt_classify u_classify (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (frame_accept),
        .flags        (flags),
        .dst_mac      (dst_mac),
        .src_mac      (src_mac),
        .frame_length (frame_length),
        .bssid        (bssid_reg),
        .watch_num    (watch_num_reg),
        .busy         (cls_busy),
        .req          (req)
    );

    // Cell chain
    assign any_hit       = |hit_vec;
    assign free_chain[0] = 1'b0;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        localparam int NB = (g + 1) % N;

        wpt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .req       (req),
            .any_hit   (any_hit),
            .free_in   (free_chain[g]),
            .free_out  (free_chain[g+1]),
            .hit       (hit_vec[g]),
            .alloc     (alloc_vec[g]),
            .shift     (shift),
            .nbr_used  (used_vec[NB]),
            .nbr_entry (cell_entry[NB]),
            .used      (used_vec[g]),
            .entry     (cell_entry[g])
        );
    end

    assign drop_next = drop_reg + {{(wpt_pkg::CNT_W-1){1'b0}},
                                   (req.valid && !any_hit && !free_chain[N])};

    // Dump sequencer
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        dmask_next     = dmask_reg;
        dcnt_next      = dcnt_reg;
        shift          = 1'b0;
        emit           = 1'b0;
        res_next       = cell_entry[0];
        res_entry_next = 1'b1;
        res_last_next  = dmask_reg[0] && ((dmask_reg >> 1) == '0);
        case (state_reg)
            wpt_pkg::ST_IDLE:
            begin
                if (in_accept && func == wpt_pkg::FUNC_DUMP)
                    state_next = wpt_pkg::ST_LOAD;
            end
            wpt_pkg::ST_LOAD:
            begin
                dmask_next = used_vec;
                dcnt_next  = '0;
                state_next = (|used_vec) ? wpt_pkg::ST_DUMP : wpt_pkg::ST_EMPTY;
            end
            wpt_pkg::ST_EMPTY:
            begin
                res_next       = '0;
                res_entry_next = 1'b0;
                res_last_next  = 1'b1;
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = wpt_pkg::ST_IDLE;
                end
            end
            wpt_pkg::ST_DUMP:
            begin
                if (out_free)
                begin
                    shift      = 1'b1;
                    emit       = dmask_reg[0];
                    dmask_next = dmask_reg >> 1;
                    dcnt_next  = dcnt_reg + wpt_pkg::SLOT_W'(1);
                    if (dcnt_reg == wpt_pkg::SLOT_W'(N - 1))
                        state_next = wpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wpt_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = emit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wpt_pkg::ST_IDLE;
            dmask_reg     <= '0;
            dcnt_reg      <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dmask_reg     <= dmask_next;
            dcnt_reg      <= dcnt_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg       <= res_next;
            res_entry_reg <= res_entry_next;
            res_last_reg  <= res_last_next;
            res_drop_reg  <= drop_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pair_bssid     = res_reg.bssid;
    assign pair_station   = res_reg.station;
    assign rx_byte_total  = res_reg.rx_octets;
    assign rx_frame_total = res_reg.rx_frames;
    assign tx_byte_total  = res_reg.tx_octets;
    assign tx_frame_total = res_reg.tx_frames;
    assign tx_retry_total = res_reg.tx_retry_cnt;
    assign drop_total     = res_drop_reg;
    assign entry_valid    = res_entry_reg;
    assign last           = res_last_reg;

    // Keys are unique across used cells
    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> $onehot0(hit_vec))
        else $error("more than one cell matched a key");

    a_alloc_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(alloc_vec) && !(any_hit && (|alloc_vec)))
        else $error("bad allocation");

    a_no_update_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wpt_pkg::ST_DUMP || state_reg == wpt_pkg::ST_LOAD) |-> !req.valid)
        else $error("table update during dump");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && !any_hit && !free_chain[N]) |=> (drop_reg == $past(drop_reg) + 32'd1))
        else $error("drop count missed");

endmodule

FILE: design/wpt_cell.sv
// One table entry: key match, allocation, counter update and dump rotation.
module wpt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  wpt_pkg::req_t   req,
    input  logic            any_hit,
    input  logic            free_in,
    output logic            free_out,
    output logic            hit,
    output logic            alloc,
    input  logic            shift,
    input  logic            nbr_used,
    input  wpt_pkg::entry_t nbr_entry,
    output logic            used,
    output wpt_pkg::entry_t entry
);

    logic            used_reg;
    logic            used_next;
    wpt_pkg::entry_t data_reg;
    wpt_pkg::entry_t data_next;
    wpt_pkg::cnt_t   len_ext;

    assign len_ext  = {{(wpt_pkg::CNT_W - wpt_pkg::LEN_W){1'b0}}, req.len};
    assign hit      = used_reg && data_reg.bssid == req.bssid
                      && data_reg.station == req.station;
    assign alloc    = req.valid && !any_hit && !used_reg && !free_in;
    assign free_out = free_in || !used_reg;
    assign used     = used_reg;
    assign entry    = data_reg;

    always_comb
    begin
        used_next = used_reg;
        data_next = data_reg;
        if (shift)
        begin
            used_next = nbr_used;
            data_next = nbr_entry;
        end
        else if (req.valid && (hit || alloc))
        begin
            if (alloc)
            begin
                used_next              = 1'b1;
                data_next.bssid        = req.bssid;
                data_next.station      = req.station;
                data_next.rx_octets    = '0;
                data_next.rx_frames    = '0;
                data_next.tx_octets    = '0;
                data_next.tx_frames    = '0;
                data_next.tx_retry_cnt = '0;
            end
            case (req.op)
                wpt_pkg::OP_RX:
                begin
                    data_next.rx_octets = data_next.rx_octets + len_ext;
                    data_next.rx_frames = data_next.rx_frames + 32'd1;
                end
                wpt_pkg::OP_TX:
                begin
                    data_next.tx_octets = data_next.tx_octets + len_ext;
                    data_next.tx_frames = data_next.tx_frames + 32'd1;
                end
                wpt_pkg::OP_RETRY:
                begin
                    data_next.tx_retry_cnt = data_next.tx_retry_cnt + 32'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= 1'b0;
        else
            used_reg <= used_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

FILE: design/wpt_classify.sv
// Input register and frame classifier: watched address match and pair key.
module wpt_classify (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [wpt_pkg::FLAGS_W-1:0]   flags,
    input  wpt_pkg::mac_t                 dst_mac,
    input  wpt_pkg::mac_t                 src_mac,
    input  logic [wpt_pkg::LEN_W-1:0]     frame_length,
    input  wpt_pkg::bssid_set_t           bssid,
    input  logic [wpt_pkg::BCNT_W-1:0]    watch_num,
    output logic                          busy,
    output wpt_pkg::req_t                 req
);

    logic                          s1_valid_reg;
    logic [wpt_pkg::FLAGS_W-1:0]   flags_reg;
    wpt_pkg::mac_t                 dst_reg;
    wpt_pkg::mac_t                 src_reg;
    logic [wpt_pkg::LEN_W-1:0]     len_reg;
    logic [wpt_pkg::BCNT_W-1:0]    n_watch;
    logic                          dst_w;
    logic                          src_w;
    wpt_pkg::req_t                 req_reg;
    wpt_pkg::req_t                 req_next;

    assign n_watch = (watch_num > wpt_pkg::BCNT_W'(wpt_pkg::MAX_BSSIDS))
                     ? wpt_pkg::BCNT_W'(wpt_pkg::MAX_BSSIDS) : watch_num;

    always_comb
    begin
        dst_w = 1'b0;
        src_w = 1'b0;
        for (int i = 0; i < wpt_pkg::NUM_BSSID_REGS; i++)
        begin
            if (wpt_pkg::BCNT_W'(i) < n_watch && bssid[i] == dst_reg)
                dst_w = 1'b1;
            if (wpt_pkg::BCNT_W'(i) < n_watch && bssid[i] == src_reg)
                src_w = 1'b1;
        end
    end

    always_comb
    begin
        req_next.valid   = 1'b0;
        req_next.op      = wpt_pkg::OP_NONE;
        req_next.bssid   = dst_reg;
        req_next.station = src_reg;
        req_next.len     = len_reg;
        if (s1_valid_reg && flags_reg[1:0] != wpt_pkg::DS_MASK)
        begin
            if (dst_w)
            begin
                req_next.valid = 1'b1;
                req_next.op    = wpt_pkg::OP_RX;
            end
            else if (src_w && dst_reg != wpt_pkg::BCAST_MAC)
            begin
                req_next.valid   = 1'b1;
                req_next.op      = flags_reg[wpt_pkg::RETRY_BIT] ? wpt_pkg::OP_RETRY
                                                                 : wpt_pkg::OP_TX;
                req_next.bssid   = src_reg;
                req_next.station = dst_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            req_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            req_reg      <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            flags_reg <= flags;
            dst_reg   <= dst_mac;
            src_reg   <= src_mac;
            len_reg   <= frame_length;
        end
    end

    assign busy = s1_valid_reg;
    assign req  = req_reg;

endmodule

FILE: tb/wifi_pair_traffic_counter_unit_tb.sv
// Self-checking testbench for the pair traffic counter: predicts dump results and compares.
module wifi_pair_traffic_counter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STA_POOL       = 4;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 40;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                        func;
        logic [wpt_pkg::FLAGS_W-1:0] flags;
        wpt_pkg::mac_t               dst;
        wpt_pkg::mac_t               src;
        logic [wpt_pkg::LEN_W-1:0]   len;
    } frame_rec_t;

    typedef struct packed {
        wpt_pkg::mac_t bssid;
        wpt_pkg::mac_t station;
        wpt_pkg::cnt_t rx_octets;
        wpt_pkg::cnt_t rx_frames;
        wpt_pkg::cnt_t tx_octets;
        wpt_pkg::cnt_t tx_frames;
        wpt_pkg::cnt_t tx_retry_cnt;
        wpt_pkg::cnt_t drops;
        logic          entry_valid;
        logic          last;
    } pair_report_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [wpt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wpt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           func = 1'b0;
    logic [wpt_pkg::FLAGS_W-1:0]    flags = '0;
    logic [wpt_pkg::MAC_W-1:0]      dst_mac = '0;
    logic [wpt_pkg::MAC_W-1:0]      src_mac = '0;
    logic [wpt_pkg::LEN_W-1:0]      frame_length = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [wpt_pkg::MAC_W-1:0]      pair_bssid;
    logic [wpt_pkg::MAC_W-1:0]      pair_station;
    logic [wpt_pkg::CNT_W-1:0]      rx_byte_total;
    logic [wpt_pkg::CNT_W-1:0]      rx_frame_total;
    logic [wpt_pkg::CNT_W-1:0]      tx_byte_total;
    logic [wpt_pkg::CNT_W-1:0]      tx_frame_total;
    logic [wpt_pkg::CNT_W-1:0]      tx_retry_total;
    logic [wpt_pkg::CNT_W-1:0]      drop_total;
    logic                           entry_valid;
    logic                           last;

    wifi_pair_traffic_counter_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .flags          (flags),
        .dst_mac        (dst_mac),
        .src_mac        (src_mac),
        .frame_length   (frame_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pair_bssid     (pair_bssid),
        .pair_station   (pair_station),
        .rx_byte_total  (rx_byte_total),
        .rx_frame_total (rx_frame_total),
        .tx_byte_total  (tx_byte_total),
        .tx_frame_total (tx_frame_total),
        .tx_retry_total (tx_retry_total),
        .drop_total     (drop_total),
        .entry_valid    (entry_valid),
        .last           (last)
    );

    always #5 clk = ~clk;

    // predicted table and configuration
    logic                       pair_used [wpt_pkg::TABLE_ENTRIES];
    wpt_pkg::entry_t            pair_tab [wpt_pkg::TABLE_ENTRIES];
    wpt_pkg::cnt_t              pair_drops;
    wpt_pkg::mac_t              watch_ap [wpt_pkg::NUM_BSSID_REGS];
    logic [wpt_pkg::BCNT_W-1:0] watch_count;

    pair_report_t  pending_reports [$];
    int            fail_count = 0;
    bit            idle_on = 1'b1;
    bit            long_hold_req = 1'b0;
    wpt_pkg::mac_t ap_pool [wpt_pkg::NUM_BSSID_REGS];
    wpt_pkg::mac_t sta_pool [STA_POOL];

    function automatic wpt_pkg::mac_t rand_mac();
        logic [15:0] hi;
        hi = 16'($urandom);
        return {hi, 32'($urandom)};
    endfunction

    function automatic logic is_watched_ap(wpt_pkg::mac_t mac);
        int n;
        n = (watch_count > wpt_pkg::MAX_BSSIDS) ? wpt_pkg::MAX_BSSIDS : int'(watch_count);
        for (int i = 0; i < n && i < wpt_pkg::NUM_BSSID_REGS; i++)
        begin
            if (watch_ap[i] == mac)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int claim_pair(wpt_pkg::mac_t ap, wpt_pkg::mac_t sta);
        int free_idx;
        free_idx = -1;
        for (int i = 0; i < wpt_pkg::TABLE_ENTRIES; i++)
        begin
            if (pair_used[i])
            begin
                if (pair_tab[i].bssid == ap && pair_tab[i].station == sta)
                    return i;
            end
            else if (free_idx < 0)
                free_idx = i;
        end
        if (free_idx >= 0)
        begin
            pair_used[free_idx] = 1'b1;
            pair_tab[free_idx] = '0;
            pair_tab[free_idx].bssid = ap;
            pair_tab[free_idx].station = sta;
        end
        return free_idx;
    endfunction

    function automatic void push_report(int idx, logic is_last);
        pair_report_t r;
        r = '0;
        if (idx >= 0)
        begin
            r.bssid        = pair_tab[idx].bssid;
            r.station      = pair_tab[idx].station;
            r.rx_octets    = pair_tab[idx].rx_octets;
            r.rx_frames    = pair_tab[idx].rx_frames;
            r.tx_octets    = pair_tab[idx].tx_octets;
            r.tx_frames    = pair_tab[idx].tx_frames;
            r.tx_retry_cnt = pair_tab[idx].tx_retry_cnt;
            r.entry_valid  = 1'b1;
        end
        r.drops = pair_drops;
        r.last  = is_last;
        pending_reports.push_back(r);
    endfunction

    function automatic void tally_record(frame_rec_t rec);
        int idx;
        int last_idx;
        if (rec.func == wpt_pkg::FUNC_DUMP)
        begin
            last_idx = -1;
            for (int i = 0; i < wpt_pkg::TABLE_ENTRIES; i++)
            begin
                if (pair_used[i])
                    last_idx = i;
            end
            if (last_idx < 0)
                push_report(-1, 1'b1);
            else
            begin
                for (int i = 0; i < wpt_pkg::TABLE_ENTRIES; i++)
                begin
                    if (pair_used[i])
                        push_report(i, i == last_idx);
                end
            end
            return;
        end
        if (rec.flags[1:0] == wpt_pkg::DS_MASK)
            return;
        if (is_watched_ap(rec.dst))
        begin
            idx = claim_pair(rec.dst, rec.src);
            if (idx < 0)
            begin
                pair_drops = pair_drops + wpt_pkg::cnt_t'(1);
                return;
            end
            pair_tab[idx].rx_octets = pair_tab[idx].rx_octets + wpt_pkg::cnt_t'(rec.len);
            pair_tab[idx].rx_frames = pair_tab[idx].rx_frames + wpt_pkg::cnt_t'(1);
        end
        else if (is_watched_ap(rec.src))
        begin
            if (rec.dst == wpt_pkg::BCAST_MAC)
                return;
            idx = claim_pair(rec.src, rec.dst);
            if (idx < 0)
            begin
                pair_drops = pair_drops + wpt_pkg::cnt_t'(1);
                return;
            end
            if (rec.flags[wpt_pkg::RETRY_BIT])
                pair_tab[idx].tx_retry_cnt = pair_tab[idx].tx_retry_cnt + wpt_pkg::cnt_t'(1);
            else
            begin
                pair_tab[idx].tx_octets = pair_tab[idx].tx_octets + wpt_pkg::cnt_t'(rec.len);
                pair_tab[idx].tx_frames = pair_tab[idx].tx_frames + wpt_pkg::cnt_t'(1);
            end
        end
    endfunction

    function automatic frame_rec_t make_frame(logic [wpt_pkg::FLAGS_W-1:0] fl,
                                              wpt_pkg::mac_t dst, wpt_pkg::mac_t src,
                                              logic [wpt_pkg::LEN_W-1:0] len);
        frame_rec_t rec;
        rec.func  = wpt_pkg::FUNC_FRAME;
        rec.flags = fl;
        rec.dst   = dst;
        rec.src   = src;
        rec.len   = len;
        return rec;
    endfunction

    function automatic frame_rec_t dump_req();
        frame_rec_t rec;
        rec = make_frame(wpt_pkg::FLAGS_W'($urandom), rand_mac(), rand_mac(),
                         wpt_pkg::LEN_W'($urandom));
        rec.func = wpt_pkg::FUNC_DUMP;
        return rec;
    endfunction

    function automatic frame_rec_t random_record();
        frame_rec_t rec;
        int pick;
        int sub;
        rec = make_frame(wpt_pkg::FLAGS_W'($urandom), rand_mac(), rand_mac(),
                         wpt_pkg::LEN_W'($urandom));
        pick = $urandom_range(99, 0);
        sub = $urandom_range(49, 0);
        if (pick < 8)
            rec.func = wpt_pkg::FUNC_DUMP;
        else if (pick < 55)
        begin
            rec.dst = ap_pool[$urandom_range(wpt_pkg::NUM_BSSID_REGS - 1, 0)];
            if (sub != 0)
                rec.src = sta_pool[$urandom_range(STA_POOL - 1, 0)];
        end
        else if (pick < 90)
        begin
            rec.src = ap_pool[$urandom_range(wpt_pkg::NUM_BSSID_REGS - 1, 0)];
            if (sub < 2)
                rec.dst = wpt_pkg::BCAST_MAC;
            else if (sub != 2)
                rec.dst = sta_pool[$urandom_range(STA_POOL - 1, 0)];
        end
        if (rec.flags[1:0] == wpt_pkg::DS_MASK && $urandom_range(1, 0) == 1)
            rec.flags[0] = 1'b0;
        if ($urandom_range(9, 0) == 0)
            rec.len = ($urandom_range(1, 0) == 1) ? '1 : '0;
        return rec;
    endfunction

    function automatic string report_text(pair_report_t r);
        return $sformatf("ap=%h sta=%h rx=%h/%h tx=%h/%h retry=%h drop=%h valid=%b last=%b",
                         r.bssid, r.station, r.rx_octets, r.rx_frames, r.tx_octets,
                         r.tx_frames, r.tx_retry_cnt, r.drops, r.entry_valid, r.last);
    endfunction

    task automatic offer_record(input frame_rec_t rec);
        int gap;
        gap = idle_on ? $urandom_range(10, 0) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= rec.func;
        flags        <= rec.flags;
        dst_mac      <= rec.dst;
        src_mac      <= rec.src;
        frame_length <= rec.len;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tally_record(rec);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wpt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wpt_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == wpt_pkg::CFG_WATCH_NUM)
            watch_count = data[wpt_pkg::BCNT_W-1:0];
        else if (idx < wpt_pkg::NUM_BSSID_REGS)
            watch_ap[idx] = data[wpt_pkg::MAC_W-1:0];
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_watch(input int count);
        settle();
        for (int i = 0; i < wpt_pkg::NUM_BSSID_REGS; i++)
            write_reg(wpt_pkg::CFG_IDX_W'(i), ap_pool[i]);
        write_reg(wpt_pkg::CFG_WATCH_NUM, wpt_pkg::CFG_DATA_W'(count));
    endtask

    task automatic test_directed();
        wpt_pkg::mac_t ap_a;
        wpt_pkg::mac_t ap_b;
        wpt_pkg::mac_t sta_1;
        wpt_pkg::mac_t sta_2;
        wpt_pkg::mac_t sta_3;
        ap_a  = rand_mac();
        ap_b  = rand_mac();
        sta_1 = rand_mac();
        sta_2 = rand_mac();
        sta_3 = rand_mac();
        ap_pool[0] = ap_a;
        ap_pool[1] = ap_b;
        ap_pool[2] = '0;
        ap_pool[3] = wpt_pkg::BCAST_MAC;
        load_watch(wpt_pkg::MAX_BSSIDS);
        offer_record(dump_req());                                   // empty table
        offer_record(make_frame(8'h00, ap_a, sta_1, '1));
        offer_record(make_frame(8'h08, ap_a, sta_1, '0));           // retry bit, rx side
        offer_record(make_frame(8'h08, sta_2, ap_b, 16'd1500));     // new pair starts as retry
        offer_record(make_frame(8'h01, sta_2, ap_b, 16'd1234));
        offer_record(make_frame(8'h02, sta_2, ap_b, 16'd1));
        offer_record(make_frame(8'h03, ap_a, sta_3, 16'd64));       // both DS bits
        offer_record(make_frame(8'hFF, sta_2, ap_b, 16'd64));
        offer_record(make_frame(8'h00, sta_3, sta_2, 16'd64));      // unknown addresses
        offer_record(make_frame(8'h00, '0, sta_1, 16'd100));
        offer_record(make_frame(8'h00, ap_a, ap_b, 16'd200));       // both watched
        offer_record(make_frame(8'h00, wpt_pkg::BCAST_MAC, ap_a, 16'd300));
        offer_record(dump_req());
        load_watch(3);
        offer_record(make_frame(8'h00, wpt_pkg::BCAST_MAC, ap_a, 16'd300));
        offer_record(make_frame(8'hF4, sta_1, ap_a, '1));
        offer_record(dump_req());
        load_watch(0);
        offer_record(make_frame(8'h00, ap_a, sta_1, 16'd10));
        offer_record(make_frame(8'h00, sta_1, ap_a, 16'd10));
        offer_record(dump_req());
        load_watch(7);                                               // above range
        offer_record(make_frame(8'h00, wpt_pkg::BCAST_MAC, sta_3, 16'd40));
        offer_record(dump_req());
    endtask

    task automatic test_random_mix();
        int counts [6] = '{4, 1, 7, 0, 2, 3};
        for (int i = 0; i < wpt_pkg::NUM_BSSID_REGS; i++)
            ap_pool[i] = rand_mac();
        for (int i = 0; i < STA_POOL; i++)
            sta_pool[i] = rand_mac();
        for (int p = 0; p < 6; p++)
        begin
            load_watch(counts[p]);
            idle_on = (p != 1);
            repeat ((counts[p] == 0) ? 25 : 55) offer_record(random_record());
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        settle();
        long_hold_req = 1'b1;
        idle_on = 1'b0;
        offer_record(dump_req());
        repeat (12) offer_record(random_record());
        offer_record(dump_req());
        repeat (4) offer_record(random_record());
        settle();
        idle_on = 1'b1;
    endtask

    task automatic test_table_full();
        ap_pool[3] = rand_mac();
        load_watch(wpt_pkg::MAX_BSSIDS);
        for (int i = 0; i < 40; i++)
        begin
            if (i % 2 == 0)
                offer_record(make_frame(8'h00, ap_pool[3], rand_mac(),
                                        wpt_pkg::LEN_W'($urandom)));
            else
                offer_record(make_frame(wpt_pkg::FLAGS_W'($urandom_range(15, 0)) & 8'h0C,
                                        rand_mac(), ap_pool[3],
                                        wpt_pkg::LEN_W'($urandom)));
        end
        offer_record(dump_req());
        offer_record(make_frame(8'h08, rand_mac(), ap_pool[3], 16'd5));
        offer_record(dump_req());
    endtask

    task automatic test_random_full_table();
        load_watch(wpt_pkg::MAX_BSSIDS);
        repeat (50) offer_record(random_record());
        idle_on = 1'b0;
        repeat (50) offer_record(random_record());
        idle_on = 1'b1;
    endtask

    initial
    begin
        for (int i = 0; i < wpt_pkg::TABLE_ENTRIES; i++)
        begin
            pair_used[i] = 1'b0;
            pair_tab[i] = '0;
        end
        for (int i = 0; i < wpt_pkg::NUM_BSSID_REGS; i++)
            watch_ap[i] = '0;
        watch_count = '0;
        pair_drops = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix();
        test_backpressure();
        test_table_full();
        test_random_full_table();
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : report_sink
        int hold_left;
        int pause_left;
        pair_report_t got;
        pair_report_t want;
        hold_left = 0;
        pause_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.bssid        = pair_bssid;
                got.station      = pair_station;
                got.rx_octets    = rx_byte_total;
                got.rx_frames    = rx_frame_total;
                got.tx_octets    = tx_byte_total;
                got.tx_frames    = tx_frame_total;
                got.tx_retry_cnt = tx_retry_total;
                got.drops        = drop_total;
                got.entry_valid  = entry_valid;
                got.last         = last;
                if (pending_reports.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected item: %s", $realtime, report_text(got));
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (got.bssid !== want.bssid || got.station !== want.station ||
                        got.rx_octets !== want.rx_octets ||
                        got.rx_frames !== want.rx_frames ||
                        got.tx_octets !== want.tx_octets ||
                        got.tx_frames !== want.tx_frames ||
                        got.tx_retry_cnt !== want.tx_retry_cnt ||
                        got.drops !== want.drops ||
                        got.entry_valid !== want.entry_valid || got.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: mismatch", $realtime);
                            $display("  expected %s", report_text(want));
                            $display("  actual   %s", report_text(got));
                        end
                    end
                end
                pause_left = idle_on ? $urandom_range(10, 0) : 0;
            end
            else if (pause_left == 0 && idle_on && $urandom_range(7, 0) == 0)
                pause_left = $urandom_range(10, 1);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            out_stall <= (hold_left > 0) || (pause_left > 0);
            if (pause_left > 0)
                pause_left--;
            if (hold_left > 0)
                hold_left--;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
